// File: src/lsac_pkg.sv
// shared types and constants for the line sensor centroid block
package lsac_pkg;

    localparam int CENTER_W = 4;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 2;
    localparam int LIMIT_W  = 5;
    localparam int OUT_W    = 24;

    localparam logic CFG_MIN_WIDTH = 1'b0;
    localparam logic CFG_MAX_WIDTH = 1'b1;

    localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SUM   = 10'b00_0000_0010,
        ST_SUMD  = 10'b00_0000_0100,
        ST_DIVTF = 10'b00_0000_1000,
        ST_DIVTR = 10'b00_0001_0000,
        ST_CNT   = 10'b00_0010_0000,
        ST_CNTD  = 10'b00_0100_0000,
        ST_DIVCF = 10'b00_1000_0000,
        ST_DIVCR = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

endpackage

// File: src/lsac_ram.sv
// generic single-port-write ram with registered read
module lsac_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lsac_div.sv
// shared restoring divider, one quotient bit per cycle
module lsac_div
    import lsac_pkg::*;
#(
    parameter int DVD_W = 18,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot,
    output t_div_stat        o_stat
);

    localparam int CYC_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CYC_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CYC_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && $past(r_busy))) else $error("divider done without run");

endmodule

// File: src/line_sensor_array_centroid_top.sv
// line sensor array threshold and centroid, top level with sequencer
//
// channel  dir  handshake                  payload
// s_axis   in   i_s_tvalid / o_s_tready    front_sample, rear_sample
// m_axis   out  o_m_tvalid / i_m_tready    centers, counts, line_mode
// cfg      in   i_cfg_valid / o_cfg_ready  register index, 5-bit value
//
// each sample pair beat is written to the sample rams as it is taken
// after the last sensor index the sequencer sweeps the rams (N reads) to sum the
// weighted samples, drains, does one reciprocal multiply per threshold, sweeps the
// rams (N reads) again to count lit sensors and sum their indices, drains, runs two
// passes of the ISUM_W-bit shared divider for the centers (a pass is skipped when
// its count is zero) and loads the output; o_s_tready is low meanwhile and while a
// finished result waits on a full output register
// the result sits in an output register; new beats are taken while it waits
// synchronous active-low reset; sample rams hold no reset value
module line_sensor_array_centroid_top
    import lsac_pkg::*;
#(
    parameter int SENSOR_COUNT = 16,
    parameter int WINDOW_SIZE  = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // front_sample, rear_sample, zero fill
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // front_center, rear_center, front_count, rear_count, line_mode, zero fill
    output logic [OUT_W-1:0]       o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [LIMIT_W-1:0]     i_cfg_data
);

    localparam int IDX_W   = $clog2(SENSOR_COUNT);
    localparam int CNT_W   = $clog2(SENSOR_COUNT + 1);
    localparam int ISUM_W  = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
    localparam int WT_W    = $clog2(WINDOW_SIZE + 1);
    localparam int PROD_W  = SAMPLE_BITS + WT_W;
    localparam int WSUM    = (SENSOR_COUNT - WINDOW_SIZE + 1) * WINDOW_SIZE;
    localparam int TOT_W   = SAMPLE_BITS + $clog2(WSUM + 1);
    localparam int TH_W    = SAMPLE_BITS + 1;
    localparam int DIV2    = (SENSOR_COUNT == WINDOW_SIZE) ? 1 : SENSOR_COUNT - WINDOW_SIZE;
    localparam int DIVK    = WINDOW_SIZE * DIV2;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // floor(x / DIVK) as (x * RCP_M) >> RCP_S, exact for every TOT_W-bit x
    localparam int     RCP_S = TOT_W + $clog2(DIVK);
    localparam longint RCP_M = ((longint'(1) << RCP_S) + longint'(DIVK) - 1) / longint'(DIVK);
    localparam int     RCP_W = $clog2(RCP_M + 1);
    localparam int     MUL_W = TOT_W + RCP_W;

    function automatic int f_weight(int i);
        int w;
        w = i + 1;
        if (WINDOW_SIZE < w) w = WINDOW_SIZE;
        if (SENSOR_COUNT - i < w) w = SENSOR_COUNT - i;
        if (SENSOR_COUNT - WINDOW_SIZE + 1 < w) w = SENSOR_COUNT - WINDOW_SIZE + 1;
        return w;
    endfunction

    t_state              r_state;
    t_state              n_state;
    logic [IDX_W-1:0]    r_wr_idx;
    logic [IDX_W-1:0]    r_idx;
    logic                r_pipe_vld;
    logic                r_pipe_sum;
    logic [IDX_W-1:0]    r_pipe_idx;
    logic                r_go;
    logic [TOT_W-1:0]    r_tot_f;
    logic [TOT_W-1:0]    r_tot_r;
    logic [TH_W-1:0]     r_th_f;
    logic [TH_W-1:0]     r_th_r;
    logic [CNT_W-1:0]    r_cnt_f;
    logic [CNT_W-1:0]    r_cnt_r;
    logic [ISUM_W-1:0]   r_isum_f;
    logic [ISUM_W-1:0]   r_isum_r;
    logic [CENTER_W-1:0] r_ctr_f;
    logic [CENTER_W-1:0] r_ctr_r;
    logic [LIMIT_W-1:0]  r_min_w;
    logic [LIMIT_W-1:0]  r_max_w;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out;

    logic                   in_beat;
    logic [SAMPLE_BITS-1:0] in_f;
    logic [SAMPLE_BITS-1:0] in_r;
    logic [SAMPLE_BITS-1:0] rd_f;
    logic [SAMPLE_BITS-1:0] rd_r;
    logic [WT_W-1:0]        wt;
    logic [PROD_W-1:0]      prod_f;
    logic [PROD_W-1:0]      prod_r;
    logic                   lit_f;
    logic                   lit_r;
    logic [TOT_W-1:0]       th_src;
    logic [MUL_W-1:0]       th_prod;
    logic                   div_start;
    logic [ISUM_W-1:0]      div_dvd;
    logic [CNT_W-1:0]       div_dvs;
    logic [ISUM_W-1:0]      div_q;
    t_div_stat              div_stat;
    logic                   out_free;
    logic                   fok;
    logic                   rok;
    logic [MODE_W-1:0]      mode;

    assign in_beat     = i_s_tvalid && o_s_tready;
    assign in_f        = i_s_tdata[SAMPLE_BITS-1:0];
    assign in_r        = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_vld || i_m_tready;

    lsac_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SENSOR_COUNT)) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (in_beat),
        .i_waddr (r_wr_idx),
        .i_wdata (in_f),
        .i_raddr (r_idx),
        .o_rdata (rd_f)
    );

    lsac_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SENSOR_COUNT)) u_rear_ram (
        .i_clk   (i_clk),
        .i_we    (in_beat),
        .i_waddr (r_wr_idx),
        .i_wdata (in_r),
        .i_raddr (r_idx),
        .o_rdata (rd_r)
    );

    lsac_div #(.DVD_W(ISUM_W), .DVS_W(CNT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (div_q),
        .o_stat     (div_stat)
    );

    assign wt     = WT_W'(f_weight(int'(r_pipe_idx)));
    assign prod_f = PROD_W'(rd_f) * PROD_W'(wt);
    assign prod_r = PROD_W'(rd_r) * PROD_W'(wt);
    assign lit_f  = TH_W'(rd_f) > r_th_f;
    assign lit_r  = TH_W'(rd_r) > r_th_r;

    // one shared reciprocal multiplier for both thresholds
    assign th_src  = (r_state == ST_DIVTR) ? r_tot_r : r_tot_f;
    assign th_prod = MUL_W'(th_src) * MUL_W'(RCP_M);

    assign fok = (CMP_W'(r_cnt_f) >= CMP_W'(r_min_w)) && (CMP_W'(r_cnt_f) <= CMP_W'(r_max_w));
    assign rok = (CMP_W'(r_cnt_r) >= CMP_W'(r_min_w)) && (CMP_W'(r_cnt_r) <= CMP_W'(r_max_w));

    always_comb begin
        if (fok && rok) mode = MODE_BOTH;
        else if (fok)   mode = MODE_FRONT;
        else if (rok)   mode = MODE_REAR;
        else            mode = MODE_NONE;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = r_isum_f;
        div_dvs   = r_cnt_f;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat && r_wr_idx == IDX_W'(SENSOR_COUNT - 1)) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_idx == IDX_W'(SENSOR_COUNT - 1)) n_state = ST_SUMD;
            end
            ST_SUMD: n_state = ST_DIVTF;
            ST_DIVTF: n_state = ST_DIVTR;
            ST_DIVTR: n_state = ST_CNT;
            ST_CNT: begin
                if (r_idx == IDX_W'(SENSOR_COUNT - 1)) n_state = ST_CNTD;
            end
            ST_CNTD: n_state = ST_DIVCF;
            ST_DIVCF: begin
                if (r_cnt_f == '0) begin
                    n_state = ST_DIVCR;
                end else begin
                    div_start = !r_go;
                    if (div_stat.done) n_state = ST_DIVCR;
                end
            end
            ST_DIVCR: begin
                div_dvd = r_isum_r;
                div_dvs = r_cnt_r;
                if (r_cnt_r == '0) begin
                    n_state = ST_DONE;
                end else begin
                    div_start = !r_go;
                    if (div_stat.done) n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wr_idx   <= '0;
            r_idx      <= '0;
            r_pipe_vld <= 1'b0;
            r_go       <= 1'b0;
            r_out_vld  <= 1'b0;
            r_min_w    <= LIMIT_W'(3);
            r_max_w    <= LIMIT_W'(6);
        end else begin
            r_state <= n_state;
            if (in_beat) begin
                r_wr_idx <= (r_wr_idx == IDX_W'(SENSOR_COUNT - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            r_pipe_vld <= (r_state == ST_SUM) || (r_state == ST_CNT);
            if ((r_state == ST_SUM) || (r_state == ST_CNT)) begin
                r_idx <= (r_idx == IDX_W'(SENSOR_COUNT - 1)) ? '0 : r_idx + 1'b1;
            end
            if (div_start) begin
                r_go <= 1'b1;
            end else if (div_stat.done) begin
                r_go <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MIN_WIDTH: r_min_w <= i_cfg_data;
                    CFG_MAX_WIDTH: r_max_w <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_pipe_idx <= r_idx;
        r_pipe_sum <= (r_state == ST_SUM);
        if (in_beat) begin
            r_tot_f  <= '0;
            r_tot_r  <= '0;
            r_cnt_f  <= '0;
            r_cnt_r  <= '0;
            r_isum_f <= '0;
            r_isum_r <= '0;
        end else if (r_pipe_vld && r_pipe_sum) begin
            r_tot_f <= r_tot_f + TOT_W'(prod_f);
            r_tot_r <= r_tot_r + TOT_W'(prod_r);
        end else if (r_pipe_vld) begin
            if (lit_f) begin
                r_cnt_f  <= r_cnt_f + 1'b1;
                r_isum_f <= r_isum_f + ISUM_W'(r_pipe_idx);
            end
            if (lit_r) begin
                r_cnt_r  <= r_cnt_r + 1'b1;
                r_isum_r <= r_isum_r + ISUM_W'(r_pipe_idx);
            end
        end
        if (r_state == ST_DIVTF) r_th_f <= TH_W'(th_prod >> RCP_S);
        if (r_state == ST_DIVTR) r_th_r <= TH_W'(th_prod >> RCP_S);
        if (r_state == ST_DIVCF) begin
            if (r_cnt_f == '0) r_ctr_f <= '0;
            else if (div_stat.done) r_ctr_f <= CENTER_W'(div_q);
        end
        if (r_state == ST_DIVCR) begin
            if (r_cnt_r == '0) r_ctr_r <= '0;
            else if (div_stat.done) r_ctr_r <= CENTER_W'(div_q);
        end
        if (r_state == ST_DONE && out_free) begin
            r_out <= OUT_W'({mode, COUNT_W'(r_cnt_r), COUNT_W'(r_cnt_f), r_ctr_r, r_ctr_f});
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule
